// ----- hdl/assert_macros.svh -----
// assertion macros shared by the deframer rtl
// no dependencies; SYNTH builds get empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked on every rising edge, disabled while reset is low
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)

`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

// ----- hdl/wsd_pkg.sv -----
// shared types and constants of the websocket frame deframer
// no dependencies
package wsd_pkg;

    // parser phases
    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_DEAD    = 3'd5;

    // result event codes
    localparam logic [1:0] EV_DATA  = 2'd0;
    localparam logic [1:0] EV_EMPTY = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;

    // frame opcodes that are delivered
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    // 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // pings shorter than this are marked pong-eligible
    localparam logic [63:0] PONG_LIMIT = 64'd126;

    // max_payload after reset
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'(16 * 1024 * 1024);

    // one result beat
    typedef struct packed {
        logic [1:0]  event_res;
        logic [3:0]  frame_opcode;
        logic [7:0]  data_byte;
        logic        last_of_frame;
        logic        pong_eligible;
        logic [31:0] frame_length;
    } t_result;

endpackage

// ----- hdl/wsd_parser.sv -----
// frame header and payload parser: phase state, length check, unmasking
// depends on wsd_pkg
module wsd_parser
    import wsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_accept,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic [31:0] r_max, n_max;
    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_masked, n_masked;
    logic [63:0] r_len, n_len;
    logic [2:0]  r_ext, n_ext;
    logic [31:0] r_key, n_key;
    logic [31:0] r_idx, n_idx;

    logic        wanted;

    assign wanted = (r_opcode == OP_TEXT) || (r_opcode == OP_CLOSE) || (r_opcode == OP_PING);

    // next state and result of one byte
    always_comb begin
        logic [63:0] v_len;
        logic        v_do_len;
        logic        v_do_start;
        logic [32:0] v_sum;
        logic [7:0]  v_key_b;
        logic        v_last;

        n_max    = i_cfg_we ? i_cfg_data : r_max;
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_masked = r_masked;
        n_len    = r_len;
        n_ext    = r_ext;
        n_key    = r_key;
        n_idx    = r_idx;

        o_res_valid         = 1'b0;
        o_res.event_res     = EV_DATA;
        o_res.data_byte     = 8'd0;
        o_res.last_of_frame = 1'b0;

        v_len      = r_len;
        v_do_len   = 1'b0;
        v_do_start = 1'b0;
        v_sum      = 33'd0;
        v_key_b    = 8'd0;
        v_last     = 1'b0;

        if (i_accept) begin
            case (r_phase)
                PH_HDR0: begin
                    n_opcode = i_rx_byte[3:0];
                    n_phase  = PH_HDR1;
                end
                PH_HDR1: begin
                    n_masked = i_rx_byte[7];
                    v_len    = 64'd0;
                    if (i_rx_byte[6:0] == LEN_EXT16) begin
                        n_ext   = 3'd1;
                        n_phase = PH_EXTLEN;
                    end else if (i_rx_byte[6:0] == LEN_EXT64) begin
                        n_ext   = 3'd7;
                        n_phase = PH_EXTLEN;
                    end else begin
                        v_len    = {57'd0, i_rx_byte[6:0]};
                        v_do_len = 1'b1;
                    end
                    n_len = v_len;
                end
                PH_EXTLEN: begin
                    v_len = {r_len[55:0], i_rx_byte};
                    n_len = v_len;
                    if (r_ext == 3'd0) begin
                        v_do_len = 1'b1;
                    end else begin
                        n_ext = r_ext - 3'd1;
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], i_rx_byte};
                    if (r_ext == 3'd0) begin
                        v_do_start = 1'b1;
                    end else begin
                        n_ext = r_ext - 3'd1;
                    end
                end
                PH_PAYLOAD: begin
                    // key byte i mod 4, first key byte first
                    case (r_idx[1:0])
                        2'd0:    v_key_b = r_key[31:24];
                        2'd1:    v_key_b = r_key[23:16];
                        2'd2:    v_key_b = r_key[15:8];
                        default: v_key_b = r_key[7:0];
                    endcase
                    v_sum  = {1'b0, r_idx} + 33'd1;
                    v_last = {31'd0, v_sum} >= r_len;
                    n_idx  = v_sum[31:0];
                    if (v_last) begin
                        n_phase = PH_HDR0;
                    end
                    if (wanted) begin
                        o_res_valid         = 1'b1;
                        o_res.event_res     = EV_DATA;
                        o_res.data_byte     = i_rx_byte ^ v_key_b;
                        o_res.last_of_frame = v_last;
                    end
                end
                default: begin
                    // stopped: bytes are dropped until reset
                end
            endcase

            // length complete: limit check, then mask key or payload
            if (v_do_len) begin
                if ((v_len[63:32] != 32'd0) || (v_len[31:0] > r_max)) begin
                    n_phase             = PH_DEAD;
                    o_res_valid         = 1'b1;
                    o_res.event_res     = EV_ERROR;
                    o_res.last_of_frame = 1'b1;
                end else if (n_masked) begin
                    n_ext   = 3'd3;
                    n_key   = 32'd0;
                    n_phase = PH_MASK;
                end else begin
                    n_key      = 32'd0;
                    v_do_start = 1'b1;
                end
            end

            // header done: empty frame ends here, else payload follows
            if (v_do_start) begin
                n_idx = 32'd0;
                if (v_len == 64'd0) begin
                    n_phase = PH_HDR0;
                    if (wanted) begin
                        o_res_valid         = 1'b1;
                        o_res.event_res     = EV_EMPTY;
                        o_res.last_of_frame = 1'b1;
                    end
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
        end

        o_res.frame_opcode  = r_opcode;
        o_res.pong_eligible = (o_res.event_res != EV_ERROR) && (r_opcode == OP_PING) &&
                              (v_len < PONG_LIMIT);
        o_res.frame_length  = (v_len[63:32] != 32'd0) ? 32'hFFFF_FFFF : v_len[31:0];
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= MAX_PAYLOAD_RST;
            r_phase  <= PH_HDR0;
            r_opcode <= 4'd0;
            r_masked <= 1'b0;
            r_len    <= 64'd0;
            r_ext    <= 3'd0;
            r_key    <= 32'd0;
            r_idx    <= 32'd0;
        end else begin
            r_max    <= n_max;
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_ext    <= n_ext;
            r_key    <= n_key;
            r_idx    <= n_idx;
        end
    end

endmodule

// ----- hdl/wsd_outbuf.sv -----
// two-entry result buffer: output register plus skid register
// depends on wsd_pkg
module wsd_outbuf
    import wsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_ov, n_ov;
    logic    r_sv, n_sv;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    take;

    assign take    = r_ov && !i_stall;
    assign o_full  = r_sv;
    assign o_valid = r_ov;
    assign o_data  = r_main;

    // main register refills from skid first, new beats park in skid on stall
    always_comb begin
        n_ov   = r_ov;
        n_sv   = r_sv;
        n_main = r_main;
        n_skid = r_skid;
        if (!r_ov || take) begin
            if (r_sv) begin
                n_main = r_skid;
                n_ov   = 1'b1;
                n_sv   = 1'b0;
            end else begin
                n_main = i_data;
                n_ov   = i_push;
            end
        end else if (i_push) begin
            n_skid = i_data;
            n_sv   = 1'b1;
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

// ----- hdl/websocket_frame_deframer.sv -----
// top level of the websocket client-to-server frame deframer
// depends on wsd_pkg, wsd_parser, wsd_outbuf and assert_macros.svh
//
// usage:
//   rx channel: one stream byte per beat on i_rx_byte, taken when i_rx_valid
//   is high and o_rx_stall is low.
//   event channel: one result per beat on the o_* result ports, taken when
//   o_ev_valid is high and i_ev_stall is low. Header bytes give no beat but
//   for an error or empty-frame event; payload bytes of swallowed opcodes give none.
//   config: i_cfg_we writes i_cfg_data into max_payload.
//   results: each result is registered in the output buffer before it appears.
//   throughput: one byte per cycle while o_rx_stall is low; the parser updates
//   its phase and unmasks the byte combinationally, the result register follows.
//   stall: a two-entry output buffer absorbs one more result while the
//   receiver stalls; o_rx_stall rises only when both entries are full.
//   reset: synchronous, active low; the parser returns to the first header
//   byte, max_payload returns to 16 MiB and the buffer empties. After a
//   payload-too-large event every byte is taken and dropped until reset.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_ev_valid,
    input  logic        i_ev_stall,
    output logic [1:0]  o_event_res,
    output logic [3:0]  o_frame_opcode,
    output logic [7:0]  o_data_byte,
    output logic        o_last_of_frame,
    output logic        o_pong_eligible,
    output logic [31:0] o_frame_length
);

`include "assert_macros.svh"

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    buf_full;

    assign accept     = i_rx_valid && !buf_full;
    assign o_rx_stall = buf_full;

    // byte parser
    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result buffer
    wsd_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (buf_full),
        .o_valid (o_ev_valid),
        .i_stall (i_ev_stall),
        .o_data  (out_res)
    );

    // result fields
    assign o_event_res     = out_res.event_res;
    assign o_frame_opcode  = out_res.frame_opcode;
    assign o_data_byte     = out_res.data_byte;
    assign o_last_of_frame = out_res.last_of_frame;
    assign o_pong_eligible = out_res.pong_eligible;
    assign o_frame_length  = out_res.frame_length;

    // checks
    `ASSERT_RST(a_stall_needs_valid, i_clk, i_rst_n, o_rx_stall |-> o_ev_valid, "rx stalled with empty output register")
    `ASSERT_RST(a_error_is_last, i_clk, i_rst_n, (o_ev_valid && (o_event_res == EV_ERROR)) |-> o_last_of_frame, "error event not marked last")
    `ASSERT_RST(a_event_data_zero, i_clk, i_rst_n, (o_ev_valid && (o_event_res != EV_DATA)) |-> (o_data_byte == 8'd0), "non-data event carries a data byte")
    `ASSERT_CLK(a_reset_empties, i_clk, !i_rst_n |=> (!o_ev_valid && !o_rx_stall), "buffer not empty after reset")

endmodule
